// ===== src/cles_pkg.sv =====
// Package: command codes, microcode word, program table and configuration types.
`default_nettype none
package cles_pkg;

   localparam int unsigned PC_W     = 6;
   localparam int unsigned PADDR_W  = 5;
   localparam int unsigned PDATA_W  = 32;

   typedef enum logic [3:0] {
      CMD_INIT      = 4'd0,
      CMD_STOP      = 4'd1,
      CMD_CLEAR     = 4'd2,
      CMD_HOME      = 4'd3,
      CMD_SET_ADDR  = 4'd4,
      CMD_STR_START = 4'd5,
      CMD_CHAR      = 4'd6,
      CMD_SHIFT     = 4'd7,
      CMD_LIGHT_ON  = 4'd8,
      CMD_LIGHT_OFF = 4'd9
   } cmd_type;

   typedef enum logic [2:0] {
      REG_DEV_ADDR   = 3'd0,
      REG_FONT       = 3'd1,
      REG_TWO_LINE   = 3'd2,
      REG_CURSOR     = 3'd3,
      REG_BLINK      = 3'd4,
      REG_BL_START   = 3'd5
   } reg_idx_type;

   typedef enum logic [2:0] {
      VAL_CONST = 3'd0,
      VAL_FUNC  = 3'd1,
      VAL_DISP  = 3'd2,
      VAL_ADDR  = 3'd3,
      VAL_DATA  = 3'd4,
      VAL_SHIFT = 3'd5
   } val_sel_type;

   // program entry points
   localparam logic [PC_W-1:0] ENTRY_INIT  = 6'd0;
   localparam logic [PC_W-1:0] ENTRY_STOP  = 6'd28;
   localparam logic [PC_W-1:0] ENTRY_CLEAR = 6'd32;
   localparam logic [PC_W-1:0] ENTRY_HOME  = 6'd36;
   localparam logic [PC_W-1:0] ENTRY_ADDR  = 6'd40;
   localparam logic [PC_W-1:0] ENTRY_CHAR  = 6'd44;
   localparam logic [PC_W-1:0] ENTRY_SHIFT = 6'd48;
   localparam logic [PC_W-1:0] ENTRY_LIGHT = 6'd52;

   typedef struct packed {
      logic       raw;
      val_sel_type sel;
      logic [7:0] konst;
      logic       rs;
      logic       lo;
      logic       e;
      logic [5:0] wait_ms;
      logic       last;
   } ucode_type;

   typedef struct packed {
      logic [6:0] dev_addr;
      logic       font_large;
      logic       two_line;
      logic       cursor_visible;
      logic       cursor_blink;
      logic       bl_start;
   } cfg_type;

   // one control word per byte; register writes take four steps (hi+E, hi, lo+E, lo)
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type  w;
      logic       lst;
      logic [3:0] slot;
      slot      = pc[5:2];
      lst       = 1'b0;
      w.raw     = 1'b0;
      w.sel     = VAL_CONST;
      w.konst   = 8'h00;
      w.rs      = 1'b0;
      w.lo      = pc[1];
      w.e       = ~pc[0];
      w.wait_ms = (pc[1:0] == 2'd0) ? 6'd2 : 6'd0;
      if (pc[5:3] == 3'd0) begin
         w.raw = 1'b1;
         unique case (pc[2:0])
            3'd0:    begin w.konst = 8'h34; w.wait_ms = 6'd50; end
            3'd1:    begin w.konst = 8'h30; w.wait_ms = 6'd0;  end
            3'd2:    begin w.konst = 8'h34; w.wait_ms = 6'd5;  end
            3'd3:    begin w.konst = 8'h30; w.wait_ms = 6'd0;  end
            3'd4:    begin w.konst = 8'h34; w.wait_ms = 6'd1;  end
            3'd5:    begin w.konst = 8'h30; w.wait_ms = 6'd0;  end
            3'd6:    begin w.konst = 8'h24; w.wait_ms = 6'd0;  end
            default: begin w.konst = 8'h20; w.wait_ms = 6'd0;  end
         endcase
      end else begin
         unique case (slot)
            4'd2:    w.sel = VAL_FUNC;
            4'd3:    w.konst = 8'h08;
            4'd4:    w.konst = 8'h01;
            4'd5:    w.sel = VAL_DISP;
            4'd6:    begin w.konst = 8'h06; lst = 1'b1; end
            4'd7:    w.konst = 8'h08;
            4'd8:    begin w.konst = 8'h01; lst = 1'b1; end
            4'd9:    begin w.konst = 8'h02; lst = 1'b1; end
            4'd10:   begin w.sel = VAL_ADDR; lst = 1'b1; end
            4'd11:   begin w.sel = VAL_DATA; w.rs = 1'b1; lst = 1'b1; end
            4'd12:   begin w.sel = VAL_SHIFT; lst = 1'b1; end
            4'd13:   begin w.konst = 8'h00; lst = 1'b1; end
            default: lst = 1'b1;
         endcase
      end
      w.last = lst & (pc[1:0] == 2'd3);
      return w;
   endfunction

endpackage
`default_nettype wire

// ===== src/cles_if.sv =====
// Valid/ready channel interfaces for command items and expander byte items.
`default_nettype none
interface cles_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] command;
   logic [7:0] operand;
   modport source (output valid, output command, output operand, input ready);
   modport sink   (input valid, input command, input operand, output ready);
endinterface

interface cles_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] expander_byte;
   logic [5:0] wait_before_ms;
   logic [6:0] target_address;
   logic       last;
   modport source (output valid, output expander_byte, output wait_before_ms,
                   output target_address, output last, input ready);
   modport sink   (input valid, input expander_byte, input wait_before_ms,
                   input target_address, input last, output ready);
endinterface
`default_nettype wire

// ===== src/cles_csr.sv =====
// APB-style configuration register file.
`default_nettype none
module cles_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [cles_pkg::PADDR_W-1:0]  csr_paddr,
   input  wire logic [cles_pkg::PDATA_W-1:0]  csr_pwdata,
   output logic      [cles_pkg::PDATA_W-1:0]  csr_prdata,
   output logic                               csr_pready,
   output cles_pkg::cfg_type                  cfg
);

   cles_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [2:0]        idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (cles_pkg::reg_idx_type'(idx))
            cles_pkg::REG_DEV_ADDR: cfg_in.dev_addr       = csr_pwdata[6:0];
            cles_pkg::REG_FONT:     cfg_in.font_large     = csr_pwdata[0];
            cles_pkg::REG_TWO_LINE: cfg_in.two_line       = csr_pwdata[0];
            cles_pkg::REG_CURSOR:   cfg_in.cursor_visible = csr_pwdata[0];
            cles_pkg::REG_BLINK:    cfg_in.cursor_blink   = csr_pwdata[0];
            cles_pkg::REG_BL_START: cfg_in.bl_start       = csr_pwdata[0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (cles_pkg::reg_idx_type'(idx))
         cles_pkg::REG_DEV_ADDR: csr_prdata = {25'd0, cfg_ff.dev_addr};
         cles_pkg::REG_FONT:     csr_prdata = {31'd0, cfg_ff.font_large};
         cles_pkg::REG_TWO_LINE: csr_prdata = {31'd0, cfg_ff.two_line};
         cles_pkg::REG_CURSOR:   csr_prdata = {31'd0, cfg_ff.cursor_visible};
         cles_pkg::REG_BLINK:    csr_prdata = {31'd0, cfg_ff.cursor_blink};
         cles_pkg::REG_BL_START: csr_prdata = {31'd0, cfg_ff.bl_start};
         default:                csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dev_addr       <= 7'd39;
         cfg_ff.font_large     <= 1'b0;
         cfg_ff.two_line       <= 1'b1;
         cfg_ff.cursor_visible <= 1'b0;
         cfg_ff.cursor_blink   <= 1'b0;
         cfg_ff.bl_start       <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/char_lcd_expander_sequencer.sv =====
// Top level: command dispatch, microcoded byte sequencer and output register.
//
//   channel | direction | handshake           | payload
//   req     | in        | valid/ready         | command, operand
//   rsp     | out       | valid/ready         | expander_byte, wait_before_ms,
//           |           |                     | target_address, last
//   csr     | in        | APB psel/penable    | paddr[4:0], pwdata, prdata
//
// A command is accepted while idle, then one expander byte per cycle is loaded from
// the program ROM while rsp is not stalled. The next command is taken the cycle
// after the final byte of the current one is loaded into the output register.
// Commands that emit nothing leave the sequencer idle.
// Synchronous reset clears state and loads register defaults.
// A stalled rsp holds the output register and freezes the step counter.
`default_nettype none
module char_lcd_expander_sequencer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   cles_req_if.sink                           req,
   cles_rsp_if.source                         rsp,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [cles_pkg::PADDR_W-1:0]  csr_paddr,
   input  wire logic [cles_pkg::PDATA_W-1:0]  csr_pwdata,
   output logic      [cles_pkg::PDATA_W-1:0]  csr_prdata,
   output logic                               csr_pready
);

   cles_pkg::cfg_type          cfg;
   cles_pkg::ucode_type        uw;

   logic                       busy_ff, busy_in;
   logic [cles_pkg::PC_W-1:0]  pc_ff, pc_in;
   logic [7:0]                 opd_ff, opd_in;
   logic                       bl_ff, bl_in;
   logic [7:0]                 chars_ff, chars_in;

   logic                       ovalid_ff, ovalid_in;
   logic [7:0]                 obyte_ff, obyte_in;
   logic [5:0]                 owait_ff, owait_in;
   logic [6:0]                 oaddr_ff, oaddr_in;
   logic                       olast_ff, olast_in;

   logic                       accept, step;
   logic                       go;
   logic [cles_pkg::PC_W-1:0]  entry;
   logic [7:0]                 val;
   logic [3:0]                 nib;

   cles_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign req.ready = ~busy_ff;
   assign accept    = req.valid & ~busy_ff;
   assign step      = busy_ff & (~ovalid_ff | rsp.ready);
   assign uw        = cles_pkg::ucode_rom(pc_ff);

   // dispatch: entry point, emit decision and state update per command
   always_comb begin
      go       = 1'b0;
      entry    = cles_pkg::ENTRY_INIT;
      bl_in    = bl_ff;
      chars_in = chars_ff;
      unique case (cles_pkg::cmd_type'(req.command))
         cles_pkg::CMD_INIT: begin
            go = 1'b1; entry = cles_pkg::ENTRY_INIT; bl_in = cfg.bl_start;
         end
         cles_pkg::CMD_STOP: begin
            go = 1'b1; entry = cles_pkg::ENTRY_STOP; bl_in = 1'b0;
         end
         cles_pkg::CMD_CLEAR: begin go = 1'b1; entry = cles_pkg::ENTRY_CLEAR; end
         cles_pkg::CMD_HOME:  begin go = 1'b1; entry = cles_pkg::ENTRY_HOME; end
         cles_pkg::CMD_SET_ADDR: begin
            go = ~req.operand[7]; entry = cles_pkg::ENTRY_ADDR;
         end
         cles_pkg::CMD_STR_START: begin
            go       = ~req.operand[7];
            entry    = cles_pkg::ENTRY_ADDR;
            chars_in = req.operand[7] ? 8'd0 : 8'd128 - req.operand;
         end
         cles_pkg::CMD_CHAR: begin
            entry = cles_pkg::ENTRY_CHAR;
            if (req.operand == 8'd0) begin
               chars_in = 8'd0;
            end else if (chars_ff != 8'd0) begin
               go       = 1'b1;
               chars_in = chars_ff - 8'd1;
            end
         end
         cles_pkg::CMD_SHIFT: begin go = 1'b1; entry = cles_pkg::ENTRY_SHIFT; end
         cles_pkg::CMD_LIGHT_ON: begin
            go = 1'b1; entry = cles_pkg::ENTRY_LIGHT; bl_in = 1'b1;
         end
         cles_pkg::CMD_LIGHT_OFF: begin
            go = 1'b1; entry = cles_pkg::ENTRY_LIGHT; bl_in = 1'b0;
         end
         default: go = 1'b0;
      endcase
   end

   // datapath value for the current control word
   always_comb begin
      unique case (uw.sel)
         cles_pkg::VAL_FUNC:  val = {4'h2, cfg.two_line, cfg.font_large, 2'b00};
         cles_pkg::VAL_DISP:  val = {6'b000011, cfg.cursor_visible, cfg.cursor_blink};
         cles_pkg::VAL_ADDR:  val = {1'b1, opd_ff[6:0]};
         cles_pkg::VAL_DATA:  val = opd_ff;
         cles_pkg::VAL_SHIFT: val = {5'b00011, opd_ff[0], 2'b00};
         default:             val = uw.konst;
      endcase
      nib = uw.lo ? val[3:0] : val[7:4];
   end

   always_comb begin
      busy_in   = busy_ff;
      pc_in     = pc_ff;
      opd_in    = opd_ff;
      ovalid_in = ovalid_ff & ~rsp.ready;
      obyte_in  = obyte_ff;
      owait_in  = owait_ff;
      oaddr_in  = oaddr_ff;
      olast_in  = olast_ff;
      if (accept) begin
         busy_in = go;
         pc_in   = entry;
         opd_in  = req.operand;
      end
      if (step) begin
         ovalid_in = 1'b1;
         obyte_in  = uw.raw ? uw.konst : {nib, bl_ff, uw.e, 1'b0, uw.rs};
         owait_in  = uw.wait_ms;
         oaddr_in  = cfg.dev_addr;
         olast_in  = uw.last;
         pc_in     = pc_ff + 6'd1;
         busy_in   = ~uw.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         pc_ff     <= '0;
         bl_ff     <= 1'b0;
         chars_ff  <= 8'd0;
         ovalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         pc_ff     <= pc_in;
         ovalid_ff <= ovalid_in;
         if (accept) begin
            bl_ff    <= bl_in;
            chars_ff <= chars_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      opd_ff   <= opd_in;
      obyte_ff <= obyte_in;
      owait_ff <= owait_in;
      oaddr_ff <= oaddr_in;
      olast_ff <= olast_in;
   end

   assign rsp.valid          = ovalid_ff;
   assign rsp.expander_byte  = obyte_ff;
   assign rsp.wait_before_ms = owait_ff;
   assign rsp.target_address = oaddr_ff;
   assign rsp.last           = olast_ff;

endmodule
`default_nettype wire

// ===== dv/char_lcd_expander_sequencer_checker.sv =====
// Checker: watches the command, expander byte and register ports, predicts and compares bytes.
module char_lcd_expander_sequencer_checker
   import cles_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [3:0]           req_command,
   input  logic [7:0]           req_operand,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [7:0]           rsp_expander_byte,
   input  logic [5:0]           rsp_wait_before_ms,
   input  logic [6:0]           rsp_target_address,
   input  logic                 rsp_last,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic                 csr_pready,
   input  logic [PADDR_W-1:0]   csr_paddr,
   input  logic [PDATA_W-1:0]   csr_pwdata,
   output int unsigned          fail_count,
   output int unsigned          pending
);

   localparam logic [7:0] RS_BIT         = 8'h01;
   localparam logic [7:0] E_BIT          = 8'h04;
   localparam logic [7:0] LIGHT_BIT      = 8'h08;
   localparam logic [7:0] INSTR_NOP      = 8'h00;
   localparam logic [7:0] INSTR_CLEAR    = 8'h01;
   localparam logic [7:0] INSTR_HOME     = 8'h02;
   localparam logic [7:0] INSTR_ENTRY    = 8'h06;
   localparam logic [7:0] INSTR_DISP_OFF = 8'h08;
   localparam logic [7:0] INSTR_DISP_ON  = 8'h0C;
   localparam logic [7:0] INSTR_SHIFT    = 8'h18;
   localparam logic [7:0] INSTR_FUNC     = 8'h20;
   localparam logic [7:0] INSTR_DDRAM    = 8'h80;
   localparam logic [7:0] FONT_BIT       = 8'h04;
   localparam logic [7:0] LINES_BIT      = 8'h08;
   localparam logic [7:0] CURSOR_BIT     = 8'h02;
   localparam logic [7:0] BLINK_BIT      = 8'h01;
   localparam logic [7:0] SHIFT_RIGHT    = 8'h04;
   localparam logic [7:0] MAX_ADDR       = 8'h7F;

   typedef struct packed {
      logic [7:0] xbyte;
      logic [5:0] wait_ms;
      logic [6:0] dest;
      logic       fin;
   } lcd_byte_type;

   lcd_byte_type due_bytes[$];
   cfg_type      cfg;
   logic         backlight_on;
   logic [7:0]   room_left;
   int unsigned  errors;

   assign fail_count = errors;

   function automatic void push_byte(input logic [7:0] b, input logic [5:0] w,
                                     input logic fin);
      due_bytes.push_back('{b, w, cfg.dev_addr, fin});
   endfunction

   // hi nibble with E, hi, lo nibble with E, lo
   function automatic void emit_reg(input logic rs, input logic [7:0] value,
                                    input logic fin);
      logic [7:0] base;
      logic [7:0] hi;
      logic [7:0] lo;
      base = (rs ? RS_BIT : 8'h00) | (backlight_on ? LIGHT_BIT : 8'h00);
      hi   = base | {value[7:4], 4'h0};
      lo   = base | {value[3:0], 4'h0};
      push_byte(hi | E_BIT, 6'd2, 1'b0);
      push_byte(hi, 6'd0, 1'b0);
      push_byte(lo | E_BIT, 6'd0, 1'b0);
      push_byte(lo, 6'd0, fin);
   endfunction

   function automatic void sequence_command(input logic [3:0] cmd, input logic [7:0] opd);
      case (cmd)
         CMD_INIT: begin
            backlight_on = cfg.bl_start;
            // wake-up nibbles, no backlight bit
            push_byte(8'h34, 6'd50, 1'b0);
            push_byte(8'h30, 6'd0, 1'b0);
            push_byte(8'h34, 6'd5, 1'b0);
            push_byte(8'h30, 6'd0, 1'b0);
            push_byte(8'h34, 6'd1, 1'b0);
            push_byte(8'h30, 6'd0, 1'b0);
            push_byte(8'h24, 6'd0, 1'b0);
            push_byte(8'h20, 6'd0, 1'b0);
            emit_reg(1'b0, INSTR_FUNC | (cfg.font_large ? FONT_BIT : 8'h00)
                                      | (cfg.two_line ? LINES_BIT : 8'h00), 1'b0);
            emit_reg(1'b0, INSTR_DISP_OFF, 1'b0);
            emit_reg(1'b0, INSTR_CLEAR, 1'b0);
            emit_reg(1'b0, INSTR_DISP_ON | (cfg.cursor_visible ? CURSOR_BIT : 8'h00)
                                         | (cfg.cursor_blink ? BLINK_BIT : 8'h00), 1'b0);
            emit_reg(1'b0, INSTR_ENTRY, 1'b1);
         end
         CMD_STOP: begin
            backlight_on = 1'b0;
            emit_reg(1'b0, INSTR_DISP_OFF, 1'b0);
            emit_reg(1'b0, INSTR_CLEAR, 1'b1);
         end
         CMD_CLEAR: emit_reg(1'b0, INSTR_CLEAR, 1'b1);
         CMD_HOME:  emit_reg(1'b0, INSTR_HOME, 1'b1);
         CMD_SET_ADDR: begin
            if (opd <= MAX_ADDR) emit_reg(1'b0, INSTR_DDRAM | opd, 1'b1);
         end
         CMD_STR_START: begin
            if (opd <= MAX_ADDR) begin
               room_left = 8'd128 - opd;
               emit_reg(1'b0, INSTR_DDRAM | opd, 1'b1);
            end else begin
               room_left = 8'd0;
            end
         end
         CMD_CHAR: begin
            if (opd == 8'h00) begin
               room_left = 8'd0;
            end else if (room_left != 8'd0) begin
               emit_reg(1'b1, opd, 1'b1);
               room_left = room_left - 8'd1;
            end
         end
         CMD_SHIFT: emit_reg(1'b0, INSTR_SHIFT | (opd[0] ? SHIFT_RIGHT : 8'h00), 1'b1);
         CMD_LIGHT_ON: begin
            backlight_on = 1'b1;
            emit_reg(1'b0, INSTR_NOP, 1'b1);
         end
         CMD_LIGHT_OFF: begin
            backlight_on = 1'b0;
            emit_reg(1'b0, INSTR_NOP, 1'b1);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      lcd_byte_type want;
      if (reset) begin
         cfg.dev_addr       = 7'd39;
         cfg.font_large     = 1'b0;
         cfg.two_line       = 1'b1;
         cfg.cursor_visible = 1'b0;
         cfg.cursor_blink   = 1'b0;
         cfg.bl_start       = 1'b1;
         backlight_on       = 1'b0;
         room_left          = 8'd0;
         errors             = 0;
         due_bytes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_idx_type'(csr_paddr[4:2]))
               REG_DEV_ADDR: cfg.dev_addr       = csr_pwdata[6:0];
               REG_FONT:     cfg.font_large     = csr_pwdata[0];
               REG_TWO_LINE: cfg.two_line       = csr_pwdata[0];
               REG_CURSOR:   cfg.cursor_visible = csr_pwdata[0];
               REG_BLINK:    cfg.cursor_blink   = csr_pwdata[0];
               REG_BL_START: cfg.bl_start       = csr_pwdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (due_bytes.size() == 0) begin
               $error("unexpected expander item: byte %02h", rsp_expander_byte);
               errors++;
            end else begin
               want = due_bytes.pop_front();
               if (rsp_expander_byte !== want.xbyte) begin
                  $error("expander_byte: expected %02h, actual %02h",
                         want.xbyte, rsp_expander_byte);
                  errors++;
               end
               if (rsp_wait_before_ms !== want.wait_ms) begin
                  $error("wait_before_ms: expected %0d, actual %0d",
                         want.wait_ms, rsp_wait_before_ms);
                  errors++;
               end
               if (rsp_target_address !== want.dest) begin
                  $error("target_address: expected %02h, actual %02h",
                         want.dest, rsp_target_address);
                  errors++;
               end
               if (rsp_last !== want.fin) begin
                  $error("last: expected %0b, actual %0b", want.fin, rsp_last);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) sequence_command(req_command, req_operand);
      end
      pending <= due_bytes.size();
   end

endmodule

// ===== dv/tb_char_lcd_expander_sequencer.sv =====
// Testbench top: clock, reset, command and register stimulus, receiver stalls and verdict.
module tb_char_lcd_expander_sequencer;
   import cles_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned PHASE_ITEMS = 70;
   localparam int unsigned TRAIL       = 40;

   logic                clock;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [PADDR_W-1:0]  csr_paddr;
   logic [PDATA_W-1:0]  csr_pwdata;
   logic [PDATA_W-1:0]  csr_prdata;
   logic                csr_pready;
   int unsigned         fail_count;
   int unsigned         pending;
   int unsigned         cycle_count;
   int unsigned         hold_asked;
   int unsigned         hold_taken;
   int unsigned         hold_left;
   logic                no_idle;

   cles_req_if req_if ();
   cles_rsp_if rsp_if ();

   char_lcd_expander_sequencer uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   char_lcd_expander_sequencer_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_if.valid),
      .req_ready          (req_if.ready),
      .req_command        (req_if.command),
      .req_operand        (req_if.operand),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_expander_byte  (rsp_if.expander_byte),
      .rsp_wait_before_ms (rsp_if.wait_before_ms),
      .rsp_target_address (rsp_if.target_address),
      .rsp_last           (rsp_if.last),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_pready         (csr_pready),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // receiver: random stalls, plus long hold-offs on request
   initial begin
      hold_taken = 0;
      hold_left  = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = 400;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= no_idle || ($urandom_range(99) >= 36);
         end
      end
   end

   task automatic send_item(input logic [3:0] cmd, input logic [7:0] opd);
      while (!no_idle && $urandom_range(99) < 36) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.command <= cmd;
      req_if.operand <= opd;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic csr_write(input reg_idx_type idx, input logic [PDATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [6:0] dev, input logic font, input logic two,
                            input logic cur, input logic blink, input logic bl);
      csr_write(REG_DEV_ADDR, {25'd0, dev});
      csr_write(REG_FONT, {31'd0, font});
      csr_write(REG_TWO_LINE, {31'd0, two});
      csr_write(REG_CURSOR, {31'd0, cur});
      csr_write(REG_BLINK, {31'd0, blink});
      csr_write(REG_BL_START, {31'd0, bl});
   endtask

   task automatic drain_block();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (TRAIL) @(posedge clock);
   endtask

   task automatic send_string(input logic [7:0] pos, input int unsigned nchars);
      send_item(CMD_STR_START, pos);
      repeat (nchars) send_item(CMD_CHAR, 8'($urandom_range(255, 1)));
   endtask

   // mostly strings with random content, some init, rest random commands and junk codes
   task automatic random_traffic(input int unsigned target);
      int unsigned sent;
      int unsigned kind;
      int unsigned run;
      logic [7:0]  pos;
      logic [3:0]  cmd;
      sent = 0;
      while (sent < target) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            if ($urandom_range(3) == 0) pos = 8'($urandom_range(127, 118));
            else if ($urandom_range(9) == 0) pos = 8'($urandom_range(255, 128));
            else pos = 8'($urandom_range(127));
            run = $urandom_range(12, 1);
            send_string(pos, run);
            sent += run + 1;
            if ($urandom_range(2) == 0) begin
               send_item(CMD_CHAR, 8'h00);
               sent++;
            end
         end else if (kind < 55) begin
            send_item(CMD_INIT, 8'($urandom));
            sent++;
         end else if (kind < 92) begin
            cmd = 4'($urandom_range(9));
            send_item(cmd, 8'($urandom));
            sent++;
         end else begin
            cmd = 4'($urandom);
            send_item(cmd, 8'($urandom));
            if (cmd <= CMD_LIGHT_OFF) sent++;
         end
      end
   endtask

   initial begin
      no_idle    = 1'b0;
      hold_asked = 0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.command <= 4'd0;
      req_if.operand <= 8'd0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, register defaults
      send_item(CMD_CHAR, 8'h41);       // no string open: dropped
      send_item(CMD_INIT, 8'h00);
      send_item(CMD_STR_START, 8'h00);
      send_item(CMD_CHAR, 8'hFF);
      send_item(CMD_CHAR, 8'h01);
      send_item(CMD_CHAR, 8'h00);       // terminator
      send_item(CMD_CHAR, 8'h41);
      send_item(CMD_STR_START, 8'h7F);  // room for one
      send_item(CMD_CHAR, 8'h55);
      send_item(CMD_CHAR, 8'h66);
      send_item(CMD_STR_START, 8'h80);
      send_item(CMD_CHAR, 8'h77);
      send_item(CMD_STR_START, 8'hFF);
      send_item(CMD_SET_ADDR, 8'h7F);
      send_item(CMD_SET_ADDR, 8'h80);
      send_item(CMD_SET_ADDR, 8'hFF);
      send_item(CMD_SET_ADDR, 8'h00);
      send_item(CMD_CLEAR, 8'hAA);
      send_item(CMD_HOME, 8'h55);
      send_item(CMD_SHIFT, 8'h01);
      send_item(CMD_SHIFT, 8'hFE);
      send_item(CMD_LIGHT_OFF, 8'h00);
      send_item(CMD_LIGHT_ON, 8'hFF);
      send_item(CMD_STOP, 8'h00);
      send_item(4'd10, 8'h12);
      send_item(4'd15, 8'hED);
      drain_block();

      configure(7'd0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
      send_item(CMD_INIT, 8'h00);
      random_traffic(PHASE_ITEMS);
      drain_block();

      // receiver holds off while commands keep coming
      configure(7'd127, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      send_item(CMD_INIT, 8'hFF);
      no_idle = 1'b1;
      hold_asked++;
      send_string(8'h00, 30);
      no_idle = 1'b0;
      random_traffic(PHASE_ITEMS);
      drain_block();

      configure(7'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                1'($urandom), 1'($urandom));
      no_idle = 1'b1;
      random_traffic(PHASE_ITEMS);
      no_idle = 1'b0;
      drain_block();

      repeat (2) begin
         configure(7'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                   1'($urandom), 1'($urandom));
         random_traffic(PHASE_ITEMS);
         drain_block();
      end

      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== sim.f =====
src/cles_pkg.sv
src/cles_if.sv
src/cles_csr.sv
src/char_lcd_expander_sequencer.sv
dv/char_lcd_expander_sequencer_checker.sv
dv/tb_char_lcd_expander_sequencer.sv
